// ===== hdl/console_line_editor_core_defines.svh =====
// assertion macros for the console line editor
// used by console_line_editor_core, no other dependencies
`ifndef CONSOLE_LINE_EDITOR_CORE_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CLE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cle assertion failed");

// next-cycle implication, checked outside reset
`define CLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cle assertion failed");

`endif

// ===== hdl/cle_pkg.sv =====
// types and constants of the console line editor
// no dependencies
package cle_pkg;

   localparam int RING_DEPTH = 128;                  // power of two, 4 to 4096
   localparam int ADDR_W     = $clog2(RING_DEPTH);
   localparam int PTR_W      = ADDR_W + 1;           // pointers wrap at twice the depth

   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_EOT = 8'h04;
   localparam logic [7:0] CHAR_BS  = 8'h08;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_DEL = 8'h7f;

   localparam logic [2:0] RD_BYTE     = 3'd0;
   localparam logic [2:0] RD_NEWLINE  = 3'd1;
   localparam logic [2:0] RD_EOF_USED = 3'd2;
   localparam logic [2:0] RD_EOF_KEPT = 3'd3;
   localparam logic [2:0] RD_EMPTY    = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_in;
      logic       read_started;
   } item_type;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic       line_ready;
      logic       read_valid;
      logic [7:0] read_byte;
      logic [2:0] read_status;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       load;
      logic       backspace;
      result_type result;
   } emit_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic [PTR_W-1:0] read_ptr;
      logic [PTR_W-1:0] commit_ptr;
      logic [PTR_W-1:0] edit_ptr;
   } ptrs_type;

endpackage

// ===== hdl/cle_req_if.sv =====
// request channel interface of the console line editor
// depends on nothing but plain logic types
interface cle_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_in;
   logic       read_started;

   modport source (output valid, kind, char_in, read_started, input ready);
   modport sink   (input valid, kind, char_in, read_started, output ready);
endinterface

// ===== hdl/cle_rsp_if.sv =====
// response channel interface of the console line editor
// depends on nothing but plain logic types
interface cle_rsp_if;
   logic       valid;
   logic       ready;
   logic       echo_valid;
   logic [7:0] echo_byte;
   logic       line_ready;
   logic       read_valid;
   logic [7:0] read_byte;
   logic [2:0] read_status;
   logic       last;

   modport source (output valid, echo_valid, echo_byte, line_ready, read_valid, read_byte,
                   read_status, last, input ready);
   modport sink   (input valid, echo_valid, echo_byte, line_ready, read_valid, read_byte,
                   read_status, last, output ready);
endinterface

// ===== hdl/cle_line_ram.sv =====
// byte ring storage with one write port and a registered head read
// depends on cle_pkg
module cle_line_ram (
   input  logic                      clock,
   input  cle_pkg::ram_wr_type       wr,
   input  logic [cle_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                rd_data
);

   logic [7:0] mem [cle_pkg::RING_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      // write-first on the same entry
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cle_edit_core.sv =====
// pointer state and per-item edit, commit and read logic
// depends on cle_pkg
module cle_edit_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  cle_pkg::item_type          item,
   input  logic [7:0]                 head_byte,
   output cle_pkg::ram_wr_type        wr,
   output logic [cle_pkg::ADDR_W-1:0] rd_addr,
   output cle_pkg::emit_type          emit,
   output cle_pkg::ptrs_type          ptrs
);

   cle_pkg::ptrs_type            ptrs_ff;
   cle_pkg::ptrs_type            ptrs_in;
   logic [7:0]                   ch;
   logic [cle_pkg::PTR_W-1:0]    fill;
   logic                         commit_now;

   always_comb begin
      ptrs_in    = ptrs_ff;
      wr         = '0;
      emit       = '0;
      commit_now = 1'b0;
      ch   = (item.char_in == cle_pkg::CHAR_CR) ? cle_pkg::CHAR_LF : item.char_in;
      fill = ptrs_ff.edit_ptr - ptrs_ff.read_ptr;
      if (fire) begin
         if (item.kind == cle_pkg::KIND_KEY) begin
            if ((ch == cle_pkg::CHAR_BS) || (ch == cle_pkg::CHAR_DEL)) begin
               if (ptrs_ff.edit_ptr != ptrs_ff.commit_ptr) begin
                  ptrs_in.edit_ptr            = ptrs_ff.edit_ptr - cle_pkg::PTR_W'(1);
                  emit.load                   = 1'b1;
                  emit.backspace              = 1'b1;
                  emit.result.echo_valid      = 1'b1;
                  emit.result.echo_byte       = cle_pkg::CHAR_BS;
               end
            end else if ((ch != cle_pkg::CHAR_NUL) && !fill[cle_pkg::PTR_W-1]) begin
               wr.en   = 1'b1;
               wr.addr = ptrs_ff.edit_ptr[cle_pkg::ADDR_W-1:0];
               wr.data = ch;
               ptrs_in.edit_ptr = ptrs_ff.edit_ptr + cle_pkg::PTR_W'(1);
               commit_now = (ch == cle_pkg::CHAR_LF) ||
                            (fill == cle_pkg::PTR_W'(cle_pkg::RING_DEPTH - 1));
               if (commit_now) begin
                  ptrs_in.commit_ptr = ptrs_in.edit_ptr;
               end
               emit.load              = 1'b1;
               emit.result.echo_valid = 1'b1;
               emit.result.echo_byte  = ch;
               emit.result.line_ready = commit_now;
               emit.result.last       = 1'b1;
            end
         end else begin
            emit.load              = 1'b1;
            emit.result.read_valid = 1'b1;
            emit.result.last       = 1'b1;
            if (ptrs_ff.read_ptr == ptrs_ff.commit_ptr) begin
               emit.result.read_status = cle_pkg::RD_EMPTY;
            end else if (head_byte == cle_pkg::CHAR_EOT) begin
               if (item.read_started) begin
                  emit.result.read_status = cle_pkg::RD_EOF_KEPT;
               end else begin
                  ptrs_in.read_ptr        = ptrs_ff.read_ptr + cle_pkg::PTR_W'(1);
                  emit.result.read_status = cle_pkg::RD_EOF_USED;
               end
            end else begin
               ptrs_in.read_ptr        = ptrs_ff.read_ptr + cle_pkg::PTR_W'(1);
               emit.result.read_byte   = head_byte;
               emit.result.read_status = (head_byte == cle_pkg::CHAR_LF) ?
                                         cle_pkg::RD_NEWLINE : cle_pkg::RD_BYTE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptrs_ff <= '0;
      end else begin
         ptrs_ff <= ptrs_in;
      end
   end

   assign rd_addr = ptrs_in.read_ptr[cle_pkg::ADDR_W-1:0];
   assign ptrs    = ptrs_ff;

endmodule

// ===== hdl/cle_rsp_stage.sv =====
// result register with the backspace, space, backspace echo sequencer
// depends on cle_pkg and cle_rsp_if
module cle_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  cle_pkg::emit_type emit,
   output logic              free,
   cle_rsp_if.source         rsp_chan
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_SPACE = 2'd1;
   localparam logic [1:0] PH_TAIL  = 2'd2;

   logic                 valid_ff;
   logic                 valid_in;
   logic [1:0]           phase_ff;
   logic [1:0]           phase_in;
   cle_pkg::result_type  res_ff;
   cle_pkg::result_type  res_in;

   assign free = !valid_ff || (rsp_chan.ready && res_ff.last);

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      res_in   = res_ff;
      if (free) begin
         valid_in = emit.load;
         res_in   = emit.result;
         phase_in = emit.backspace ? PH_SPACE : PH_IDLE;
      end else if (rsp_chan.ready) begin
         case (phase_ff)
            PH_SPACE: begin
               res_in.echo_byte = cle_pkg::CHAR_SP;
               phase_in         = PH_TAIL;
            end
            PH_TAIL: begin
               res_in.echo_byte = cle_pkg::CHAR_BS;
               res_in.last      = 1'b1;
               phase_in         = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PH_IDLE;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
      res_ff <= res_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.echo_valid  = res_ff.echo_valid;
   assign rsp_chan.echo_byte   = res_ff.echo_byte;
   assign rsp_chan.line_ready  = res_ff.line_ready;
   assign rsp_chan.read_valid  = res_ff.read_valid;
   assign rsp_chan.read_byte   = res_ff.read_byte;
   assign rsp_chan.read_status = res_ff.read_status;
   assign rsp_chan.last        = res_ff.last;

endmodule

// ===== hdl/console_line_editor_core.sv =====
// console line editor: canonical line buffer over a byte ring
// depends on cle_pkg, cle_req_if, cle_rsp_if, cle_line_ram, cle_edit_core,
// cle_rsp_stage and console_line_editor_core_defines.svh
//
// req_chan carries key bytes (kind 0) and read requests (kind 1); rsp_chan
// returns echo bytes, line_ready and read answers, last marking the final
// result of an item. An accepted item is held in the input register until the
// result register is free, is processed there and its first result is
// registered in the result register, which drives rsp_chan.valid. One item
// per cycle is taken while results drain; a backspace holds the result
// register for three transfers, every other item that answers for one, and
// dropped bytes for none. The ring head is prefetched from the storage every
// cycle, so back-to-back reads see the updated head.
// Reset empties the ring (all three pointers to zero) and clears both valid
// flags; stored bytes are left as they are. When the receiver stalls, the
// result register holds and the input register fills, then req_chan.ready
// drops until the pending result is taken.
`include "console_line_editor_core_defines.svh"
module console_line_editor_core (
   input  logic       clock,
   input  logic       reset,
   cle_req_if.sink    req_chan,
   cle_rsp_if.source  rsp_chan
);

   logic                       in_valid_ff;
   logic                       in_valid_in;
   cle_pkg::item_type          item_ff;
   cle_pkg::item_type          item_in;
   logic                       fire;
   logic                       out_free;
   logic [7:0]                 head_byte;
   logic [cle_pkg::ADDR_W-1:0] rd_addr;
   cle_pkg::ram_wr_type        ram_wr;
   cle_pkg::emit_type          emit;
   cle_pkg::ptrs_type          ptrs;
   logic [cle_pkg::PTR_W-1:0]  fill;
   logic [cle_pkg::PTR_W-1:0]  committed;

   assign fire           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_chan.ready) begin
         in_valid_in          = req_chan.valid;
         item_in.kind         = req_chan.kind;
         item_in.char_in      = req_chan.char_in;
         item_in.read_started = req_chan.read_started;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      item_ff <= item_in;
   end

   cle_line_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (head_byte)
   );

   cle_edit_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .head_byte (head_byte),
      .wr        (ram_wr),
      .rd_addr   (rd_addr),
      .emit      (emit),
      .ptrs      (ptrs)
   );

   cle_rsp_stage u_rsp (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

   assign fill      = ptrs.edit_ptr - ptrs.read_ptr;
   assign committed = ptrs.commit_ptr - ptrs.read_ptr;

   `CLE_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill <= cle_pkg::PTR_W'(cle_pkg::RING_DEPTH))
   `CLE_ASSERT_IMPLY(a_commit_order, clock, reset, 1'b1, committed <= fill)
   `CLE_ASSERT_NEXT(a_seq_continues, clock, reset, rsp_chan.valid && !rsp_chan.last, rsp_chan.valid)
   `CLE_ASSERT_IMPLY(a_write_in_ring, clock, reset, ram_wr.en, !fill[cle_pkg::PTR_W-1])

endmodule
